FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define USG_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define USG_ASSERT_ALL(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/usg_pkg.sv
// Types, constants and helper functions shared by the sphere mesh generator.
`default_nettype none

package usg_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_RADIUS   = 2'd0;
	localparam logic [1:0] REG_RINGS    = 2'd1;
	localparam logic [1:0] REG_SEGMENTS = 2'd2;

	// Request command codes.
	localparam logic CMD_VERTEX   = 1'b0;
	localparam logic CMD_TRIANGLE = 1'b1;

	localparam logic [6:0] MAX_RINGS    = 7'd64;
	localparam logic [6:0] MAX_SEGMENTS = 7'd64;

	// Quarter-wave sine polynomial coefficients, Q15.
	localparam logic [15:0] SIN_A   = 16'd51472;
	localparam logic [14:0] SIN_B   = 15'd21024;
	localparam logic [11:0] SIN_C   = 12'd2320;
	localparam logic [14:0] QUARTER = 15'd16384;
	localparam logic [14:0] SIN_MAX = 15'd32767;

	// Request information that bypasses the trigonometry pipeline.
	typedef struct packed {
		logic               ok;
		logic               trig;
		logic signed [16:0] pole_y;
		logic [12:0]        ia;
		logic [12:0]        ib;
		logic [12:0]        ic;
	} side_t;

	typedef struct packed {
		logic [6:0] rem;
		logic [3:0] bits;
	} div_res_t;

	// Four steps of restoring long division of a fraction rem/den (rem < den).
	function automatic div_res_t div_step4(input logic [6:0] rem_in, input logic [6:0] den);
		logic [7:0] r2;
		logic [6:0] rem;
		div_res_t   res;
		rem = rem_in;
		res.bits = '0;
		for (int i = 3; i >= 0; i--) begin
			r2 = {rem, 1'b0};
			if (r2 >= {1'b0, den}) begin
				res.bits[i] = 1'b1;
				r2 = r2 - {1'b0, den};
			end
			rem = r2[6:0];
		end
		res.rem = rem;
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/usg_decode.sv
// Request decode stage: range checks, buffer indices and divider operands.
`default_nettype none

module usg_decode import usg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic        command,
	input  wire logic [6:0]  ring,
	input  wire logic [6:0]  column,
	input  wire logic        half,
	input  wire logic [15:0] radius,
	input  wire logic [6:0]  ring_count,
	input  wire logic [6:0]  segment_count,
	output side_t            side_s1,
	output logic [6:0]       num1_s1,
	output logic [6:0]       den1_s1,
	output logic [6:0]       num2_s1,
	output logic [6:0]       den2_s1
);

	logic        cfg_ok;
	logic [7:0]  rc1;
	logic [7:0]  sc1;
	logic [12:0] total;
	logic [6:0]  ring_m1;
	logic [12:0] cur;
	logic [12:0] nxt;
	side_t       side;

	always_comb begin
		cfg_ok  = (ring_count != 7'd0) && (ring_count <= MAX_RINGS) &&
			(segment_count != 7'd0) && (segment_count <= MAX_SEGMENTS);
		rc1     = {1'b0, ring_count} + 8'd1;
		sc1     = {1'b0, segment_count} + 8'd1;
		total   = 13'(sc1) * 13'(ring_count) + 13'd2;
		ring_m1 = ring - 7'd1;
		cur     = 13'(column) + 13'(ring_m1) * 13'(sc1) + 13'd1;
		nxt     = cur + 13'(sc1);

		side = '0;
		if (cfg_ok) begin
			if (command == CMD_VERTEX) begin
				if (ring == 7'd0 && column == 7'd0) begin
					side.ok     = 1'b1;
					side.pole_y = $signed({1'b0, radius});
				end else if ({1'b0, ring} == rc1 && column == 7'd0) begin
					side.ok     = 1'b1;
					side.pole_y = -$signed({1'b0, radius});
					side.ia     = total - 13'd1;
				end else if (ring != 7'd0 && ring <= ring_count && column <= segment_count) begin
					side.ok   = 1'b1;
					side.trig = 1'b1;
					side.ia   = cur;
				end
			end else if (column < segment_count) begin
				if (ring == 7'd0 && !half) begin
					side.ok = 1'b1;
					side.ia = 13'(column) + 13'd2;
					side.ib = 13'(column) + 13'd1;
				end else if (ring == ring_count && !half) begin
					side.ok = 1'b1;
					side.ia = total - 13'd1;
					side.ib = total - 13'(column) - 13'd3;
					side.ic = total - 13'(column) - 13'd2;
				end else if (ring != 7'd0 && ring < ring_count) begin
					side.ok = 1'b1;
					side.ia = cur;
					if (!half) begin
						side.ib = cur + 13'd1;
						side.ic = nxt + 13'd1;
					end else begin
						side.ib = nxt + 13'd1;
						side.ic = nxt;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side;
			num1_s1 <= ring;
			den1_s1 <= rc1[6:0];
			num2_s1 <= (column == segment_count) ? 7'd0 : column;
			den2_s1 <= segment_count;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/usg_div_lane.sv
// Pipelined fraction divider: floor(num * 65536 / den) for num < den.
`default_nettype none

module usg_div_lane import usg_pkg::*; (
	input  wire logic        clk,
	input  wire logic [3:0]  en,
	input  wire logic [6:0]  num,
	input  wire logic [6:0]  den,
	output logic [15:0]      quo
);

	logic [6:0]  rem_s2, rem_s3, rem_s4;
	logic [6:0]  den_s2, den_s3, den_s4;
	logic [3:0]  quo_s2;
	logic [7:0]  quo_s3;
	logic [11:0] quo_s4;
	logic [15:0] quo_s5;
	div_res_t    d2, d3, d4, d5;

	always_comb begin
		d2 = div_step4(num, den);
		d3 = div_step4(rem_s2, den_s2);
		d4 = div_step4(rem_s3, den_s3);
		d5 = div_step4(rem_s4, den_s4);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s2 <= d2.rem;
			den_s2 <= den;
			quo_s2 <= d2.bits;
		end
		if (en[1]) begin
			rem_s3 <= d3.rem;
			den_s3 <= den_s2;
			quo_s3 <= {quo_s2, d3.bits};
		end
		if (en[2]) begin
			rem_s4 <= d4.rem;
			den_s4 <= den_s3;
			quo_s4 <= {quo_s3, d4.bits};
		end
		if (en[3]) begin
			quo_s5 <= {quo_s4, d5.bits};
		end
	end

	assign quo = quo_s5;

endmodule

`default_nettype wire

FILE: rtl/core/usg_sine_lane.sv
// Four-stage fixed-point sine of a 16-bit phase, result in signed Q1.15.
`default_nettype none

module usg_sine_lane import usg_pkg::*; (
	input  wire logic        clk,
	input  wire logic [3:0]  en,
	input  wire logic [15:0] phase,
	output logic signed [15:0] sine
);

	logic [14:0] x;
	logic [29:0] sq;
	logic [26:0] cz;
	logic [29:0] tz;
	logic [30:0] tx;
	logic [16:0] mag;
	logic [14:0] sat;

	logic [14:0] x_s6, z2_s6, x_s7, z2_s7, x_s8;
	logic        neg_s6, neg_s7, neg_s8;
	logic [14:0] tb_s7;
	logic [15:0] ta_s8;
	logic signed [15:0] sine_s9;

	always_comb begin
		x   = phase[14] ? (QUARTER - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
		sq  = 30'(x) * 30'(x);
		cz  = 27'(SIN_C) * 27'(z2_s6);
		tz  = 30'(tb_s7) * 30'(z2_s7);
		tx  = 31'(ta_s8) * 31'(x_s8);
		mag = tx[30:14];
		sat = (mag > 17'(SIN_MAX)) ? SIN_MAX : mag[14:0];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s6   <= x;
			z2_s6  <= sq[28:14];
			neg_s6 <= phase[15];
		end
		if (en[1]) begin
			x_s7   <= x_s6;
			z2_s7  <= z2_s6;
			neg_s7 <= neg_s6;
			tb_s7  <= SIN_B - {2'b0, cz[26:14]};
		end
		if (en[2]) begin
			x_s8   <= x_s7;
			neg_s8 <= neg_s7;
			ta_s8  <= SIN_A - tz[29:14];
		end
		if (en[3]) begin
			sine_s9 <= neg_s8 ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
		end
	end

	assign sine = sine_s9;

endmodule

`default_nettype wire

FILE: rtl/core/uv_sphere_mesh_generator.sv
// Top level of the UV-sphere mesh generator: configuration, pipeline control, final products.
`default_nettype none

// A pipeline of eleven register stages that turns one vertex or triangle request into one
// result item. It takes one item every clock cycle while the output side does not stall.
// Stage 1 decodes the request, stages 2 to 5 divide out the ring and column phases four
// quotient bits at a time, stages 6 to 9 evaluate four sines (sine and cosine of both
// angles) with one multiplier each, stage 10 forms the angle products and stage 11 scales
// by the radius into the output register. Every stage holds its item until the next stage
// has room, so a stall at the output fills bubbles first and the input is stalled only
// when the whole pipeline is full. The configuration registers (radius, ring_count,
// segment_count) reset to 256, 8 and 16 and should be written only while no item is in
// flight; an unknown register index is ignored.

module uv_sphere_mesh_generator import usg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        command,
	input  wire logic [6:0]  ring,
	input  wire logic [6:0]  column,
	input  wire logic        half,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             valid_res,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic signed [16:0] pos_z,
	output logic [12:0]      index_a,
	output logic [12:0]      index_b,
	output logic [12:0]      index_c
);

	localparam int NSTAGE = 11;

	logic [15:0] radius_q;
	logic [6:0]  ring_count_q;
	logic [6:0]  segment_count_q;

	// Stage k loads whenever it is empty or its content moves on.
	logic [NSTAGE:1] en;
	logic [NSTAGE:1] stage_vld_q;

	side_t side_s1;
	// Bypass line for the decoded request, one entry per stage 2 to 10.
	side_t side_s [2:10];
	logic [6:0]  num1_s1, den1_s1, num2_s1, den2_s1;
	logic [15:0] quo1, quo2;
	logic [15:0] ph1, ph1c, ph2c;
	logic signed [15:0] sin1, cos1, sin2, cos2;

	logic signed [16:0] rad;
	logic signed [31:0] sc_x, sc_z;
	logic signed [32:0] cy;
	logic signed [33:0] fx, fz;
	logic signed [16:0] px_s10, pz_s10, py_s10;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q        <= 16'd256;
			ring_count_q    <= 7'd8;
			segment_count_q <= 7'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS:   radius_q        <= cfg_data;
				REG_RINGS:    ring_count_q    <= cfg_data[6:0];
				REG_SEGMENTS: segment_count_q <= cfg_data[6:0];
				default:      ;
			endcase
		end
	end

	// Stall chain from the output register back to the input.
	always_comb begin
		en[NSTAGE] = !stage_vld_q[NSTAGE] || !res_stall;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			en[k] = !stage_vld_q[k] || en[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en[1]) begin
				stage_vld_q[1] <= req_valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k - 1];
				end
			end
		end
	end

	assign req_stall = !en[1];
	assign res_valid = stage_vld_q[NSTAGE];

	usg_decode u_decode (
		.clk           (clk),
		.en            (en[1]),
		.command       (command),
		.ring          (ring),
		.column        (column),
		.half          (half),
		.radius        (radius_q),
		.ring_count    (ring_count_q),
		.segment_count (segment_count_q),
		.side_s1       (side_s1),
		.num1_s1       (num1_s1),
		.den1_s1       (den1_s1),
		.num2_s1       (num2_s1),
		.den2_s1       (den2_s1)
	);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_s[2] <= side_s1;
		end
		for (int k = 3; k <= 10; k++) begin
			if (en[k]) begin
				side_s[k] <= side_s[k - 1];
			end
		end
	end

	// The ring divider works on a doubled fraction; one shift gives the half-turn phase.
	usg_div_lane u_div_ring (
		.clk (clk),
		.en  (en[5:2]),
		.num (num1_s1),
		.den (den1_s1),
		.quo (quo1)
	);

	usg_div_lane u_div_col (
		.clk (clk),
		.en  (en[5:2]),
		.num (num2_s1),
		.den (den2_s1),
		.quo (quo2)
	);

	// Cosine is the sine a quarter turn further on.
	assign ph1  = {1'b0, quo1[15:1]};
	assign ph1c = ph1 + 16'(QUARTER);
	assign ph2c = quo2 + 16'(QUARTER);

	usg_sine_lane u_sin1 (.clk(clk), .en(en[9:6]), .phase(ph1),  .sine(sin1));
	usg_sine_lane u_cos1 (.clk(clk), .en(en[9:6]), .phase(ph1c), .sine(cos1));
	usg_sine_lane u_sin2 (.clk(clk), .en(en[9:6]), .phase(quo2), .sine(sin2));
	usg_sine_lane u_cos2 (.clk(clk), .en(en[9:6]), .phase(ph2c), .sine(cos2));

	// Products truncate toward minus infinity, as the arithmetic shift does.
	assign rad  = $signed({1'b0, radius_q});
	assign sc_x = sin1 * cos2;
	assign sc_z = sin1 * sin2;
	assign cy   = cos1 * rad;
	assign fx   = px_s10 * rad;
	assign fz   = pz_s10 * rad;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			px_s10 <= $signed(sc_x[31:15]);
			pz_s10 <= $signed(sc_z[31:15]);
			py_s10 <= $signed(cy[31:15]);
		end
	end

	// Output register: poles and triangles take their fields from the bypass line.
	always_ff @(posedge clk) begin
		if (en[11]) begin
			valid_res <= side_s[10].ok;
			index_a   <= side_s[10].ia;
			index_b   <= side_s[10].ib;
			index_c   <= side_s[10].ic;
			if (side_s[10].trig) begin
				pos_x <= $signed(fx[31:15]);
				pos_y <= py_s10;
				pos_z <= $signed(fz[31:15]);
			end else begin
				pos_x <= '0;
				pos_y <= side_s[10].pole_y;
				pos_z <= '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/usg_checker.sv
// Port-level assertions for the sphere mesh generator and their bind.
`default_nettype none
`include "assert_macros.svh"

module usg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_stall,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic        valid_res,
	input wire logic signed [16:0] pos_x,
	input wire logic signed [16:0] pos_y,
	input wire logic signed [16:0] pos_z,
	input wire logic [12:0] index_a,
	input wire logic [12:0] index_b,
	input wire logic [12:0] index_c
);

	`USG_ASSERT(a_res_hold, clk, arst_n, res_valid && res_stall |=> res_valid && $stable(index_a), "stalled result changed")
	`USG_ASSERT(a_no_backpressure, clk, arst_n, !res_stall |-> !req_stall, "input stalled while output drains")
	`USG_ASSERT(a_invalid_zero, clk, arst_n, res_valid && !valid_res |-> pos_x == 17'sd0 && pos_y == 17'sd0 && pos_z == 17'sd0 && index_a == 13'd0 && index_b == 13'd0 && index_c == 13'd0, "invalid result carries data")
	`USG_ASSERT(a_tri_no_pos, clk, arst_n, res_valid && index_b != 13'd0 |-> pos_x == 17'sd0 && pos_y == 17'sd0 && pos_z == 17'sd0, "triangle result carries a position")
	// The valid bits are cleared asynchronously as soon as reset is asserted.
	`USG_ASSERT_ALL(a_reset_empty, clk, !arst_n |=> !res_valid, "result offered during reset")

endmodule

bind uv_sphere_mesh_generator usg_checker u_usg_checker (.*);

`default_nettype wire
